[hw/rtl/dpq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dpq_pkg: shared definitions for the double-ended priority queue
// Operation and status codes, default sizes and the cell control struct.
// ----------------------------------------------------------------------------
package dpq_pkg;

   // default sizes
   localparam int DefCapacity = 64;
   localparam int DefKeyBits  = 24;
   localparam int DefIdBits   = 20;

   // fixed width of the served id field on the result channel
   localparam int SERVED_BITS = 20;
   localparam int STATUS_BITS = 2;
   localparam int FUNC_BITS   = 2;

   // operation codes
   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_INSERT  = 2'd0,
      FUNC_POP_MAX = 2'd1,
      FUNC_POP_MIN = 2'd2,
      FUNC_NONE    = 2'd3
   } dpq_func_type;

   // result status codes
   typedef enum logic [STATUS_BITS-1:0] {
      ST_SERVED = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_FULL   = 2'd2,
      ST_UNUSED = 2'd3
   } dpq_status_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic ins;      // insert the new entry in sorted position
      logic pop_min;  // shift every entry one cell down
   } dpq_ctrl_type;

endpackage : dpq_pkg
`default_nettype wire

[hw/rtl/dpq_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dpq_cell: one slot of the sorted cell chain
// Holds one (key, id) entry; compares against the broadcast key, and takes
// the new entry, the lower neighbor's entry or the upper neighbor's entry.
// ----------------------------------------------------------------------------
module dpq_cell #(
   parameter int KEY_BITS = 24,
   parameter int ID_BITS  = 20,
   parameter int CNT_BITS = 7,
   parameter int INDEX    = 0
) (
   input  wire                      clock,
   input  wire dpq_pkg::dpq_ctrl_type ctrl,
   input  wire  [CNT_BITS-1:0]      count,
   input  wire  [KEY_BITS-1:0]      new_key,
   input  wire  [ID_BITS-1:0]       new_id,
   input  wire                      ge_below,
   input  wire  [KEY_BITS-1:0]      below_key,
   input  wire  [ID_BITS-1:0]       below_id,
   input  wire  [KEY_BITS-1:0]      above_key,
   input  wire  [ID_BITS-1:0]       above_id,
   output logic                     ge,
   output logic                     occ,
   output logic [KEY_BITS-1:0]      key,
   output logic [ID_BITS-1:0]       id
);
   import dpq_pkg::*;

   localparam logic [CNT_BITS-1:0] MyIndex = CNT_BITS'(INDEX);

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [ID_BITS-1:0]  id_ff, id_in;
   logic                at_end;

   // occupancy and sorted-position compare
   assign occ    = MyIndex < count;
   assign at_end = MyIndex == count;
   assign ge     = occ && (key_ff >= new_key);

   // next entry
   always_comb begin
      key_in = key_ff;
      id_in  = id_ff;
      if (ctrl.ins) begin
         if (ge_below) begin
            key_in = below_key;
            id_in  = below_id;
         end else if (ge || at_end) begin
            key_in = new_key;
            id_in  = new_id;
         end
      end else if (ctrl.pop_min) begin
         key_in = above_key;
         id_in  = above_id;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      id_ff  <= id_in;
   end

   assign key = key_ff;
   assign id  = id_ff;

endmodule : dpq_cell
`default_nettype wire

[hw/rtl/double_ended_priority_queue_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_priority_queue_unit: sorted cell chain priority queue
// Keeps up to CAPACITY (priority, client id) entries in ascending order in a
// row of cells; serves the highest or lowest entry from either end.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  req_     | in        | req_tvalid/req_tready | tuser func, tdata key and id
//  rsp_     | out       | rsp_tvalid/rsp_tready | tuser status, tdata served id
//
// all cells compare against the new key in parallel and shift in the same
// cycle, so one item is taken per clock unless the result channel stalls.
// the result sits in an output register; a new item is taken while that
// register is empty or being drained in the same cycle.
// reset clears the fill count and the output valid; cell contents need none.
// a stalled result channel holds the input channel until the result is taken.
// ----------------------------------------------------------------------------
module double_ended_priority_queue_unit #(
   parameter int CAPACITY = dpq_pkg::DefCapacity,
   parameter int KEY_BITS = dpq_pkg::DefKeyBits,
   parameter int ID_BITS  = dpq_pkg::DefIdBits,
   localparam int ReqDataBits = ((KEY_BITS + ID_BITS + 7) / 8) * 8,
   localparam int RspDataBits = ((dpq_pkg::SERVED_BITS + 7) / 8) * 8
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   // [KEY_BITS-1:0] priority_req, then client_id, then zero fill
   input  wire  [ReqDataBits-1:0]         req_tdata,
   // [1:0] func
   input  wire  [dpq_pkg::FUNC_BITS-1:0]  req_tuser,
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   // [19:0] served_id, then zero fill
   output logic [RspDataBits-1:0]         rsp_tdata,
   // [1:0] status
   output logic [dpq_pkg::STATUS_BITS-1:0] rsp_tuser
);
   import dpq_pkg::*;

   localparam int CntBits = $clog2(CAPACITY + 1);
   localparam logic [CntBits-1:0] CapCount = CntBits'(CAPACITY);

   // request fields
   logic [KEY_BITS-1:0] new_key;
   logic [ID_BITS-1:0]  new_id;
   dpq_func_type        func;
   assign new_key = req_tdata[KEY_BITS-1:0];
   assign new_id  = req_tdata[KEY_BITS+ID_BITS-1:KEY_BITS];
   assign func    = dpq_func_type'(req_tuser);

   // control state
   logic [CntBits-1:0]     count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SERVED_BITS-1:0] rsp_id_ff, rsp_id_in;
   dpq_status_type         rsp_status_ff, rsp_status_in;

   logic         accept, is_full, is_empty;
   dpq_ctrl_type ctrl;

   // cell chain wiring
   logic [KEY_BITS-1:0] cell_key [CAPACITY];
   logic [ID_BITS-1:0]  cell_id  [CAPACITY];
   logic [CAPACITY-1:0] cell_ge, cell_occ, sel_top;
   logic [ID_BITS-1:0]  max_id, served_raw;
   logic [ID_BITS+SERVED_BITS-1:0] served_wide;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_full    = count_ff == CapCount;
   assign is_empty   = count_ff == '0;

   // cell commands
   assign ctrl.ins     = accept && (func == FUNC_INSERT) && !is_full;
   assign ctrl.pop_min = accept && (func == FUNC_POP_MIN) && !is_empty;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic                ge_below;
         logic [KEY_BITS-1:0] below_key, above_key;
         logic [ID_BITS-1:0]  below_id, above_id;

         if (gi == 0) begin : g_bottom
            assign ge_below  = 1'b0;
            assign below_key = '0;
            assign below_id  = '0;
         end else begin : g_mid_lo
            assign ge_below  = cell_ge[gi-1];
            assign below_key = cell_key[gi-1];
            assign below_id  = cell_id[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_top
            assign above_key = cell_key[gi];
            assign above_id  = cell_id[gi];
            assign sel_top[gi] = cell_occ[gi];
         end else begin : g_mid_hi
            assign above_key = cell_key[gi+1];
            assign above_id  = cell_id[gi+1];
            assign sel_top[gi] = cell_occ[gi] && !cell_occ[gi+1];
         end

         dpq_cell #(
            .KEY_BITS (KEY_BITS),
            .ID_BITS  (ID_BITS),
            .CNT_BITS (CntBits),
            .INDEX    (gi)
         ) u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .count     (count_ff),
            .new_key   (new_key),
            .new_id    (new_id),
            .ge_below  (ge_below),
            .below_key (below_key),
            .below_id  (below_id),
            .above_key (above_key),
            .above_id  (above_id),
            .ge        (cell_ge[gi]),
            .occ       (cell_occ[gi]),
            .key       (cell_key[gi]),
            .id        (cell_id[gi])
         );
      end
   endgenerate

   // highest occupied cell, and-or select
   always_comb begin
      max_id = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         max_id = max_id | (cell_id[i] & {ID_BITS{sel_top[i]}});
      end
   end

   assign served_raw  = (func == FUNC_POP_MAX) ? max_id : cell_id[0];
   assign served_wide = {{SERVED_BITS{1'b0}}, served_raw};

   // count and result register next state
   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      if (accept) begin
         case (func)
            FUNC_INSERT: begin
               if (is_full) begin
                  rsp_valid_in  = 1'b1;
                  rsp_id_in     = '0;
                  rsp_status_in = ST_FULL;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            FUNC_POP_MAX, FUNC_POP_MIN: begin
               rsp_valid_in = 1'b1;
               if (is_empty) begin
                  rsp_id_in     = '0;
                  rsp_status_in = ST_EMPTY;
               end else begin
                  count_in      = count_ff - 1'b1;
                  rsp_id_in     = served_wide[SERVED_BITS-1:0];
                  rsp_status_in = ST_SERVED;
               end
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RspDataBits'(rsp_id_ff);
   assign rsp_tuser  = rsp_status_ff;

   // fill count stays within the chain
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CapCount)
      else $error("fill count above capacity");

   // at most one cell is the top of the occupied run
   a_top_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(sel_top))
      else $error("more than one top cell");

   // the number of occupied cells matches the fill count
   a_occ_count: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_occ) == int'(count_ff))
      else $error("occupancy does not match fill count");

   // pop on an empty queue reports empty
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      accept && is_empty && (func == FUNC_POP_MAX || func == FUNC_POP_MIN)
      |=> rsp_tvalid && rsp_tuser == ST_EMPTY)
      else $error("pop on empty queue not reported");

   // a good insert grows the fill count by one
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.ins |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow fill count");

endmodule : double_ended_priority_queue_unit
`default_nettype wire
